>>> rtl/pmst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmst_pkg: shared types and constants
// Sizes, payload words and the cell state of the spanning tree core.
// ---------------------------------------------------------------------------
package pmst_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int VID_BITS     = 5;
   localparam int WEIGHT_BITS  = 16;
   localparam int COUNT_BITS   = 6;
   localparam int ADDR_BITS    = 2 * VID_BITS;

   localparam logic [1:0] ST_EDGE     = 2'd0;
   localparam logic [1:0] ST_DISCONN  = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_RUN  = 1'b1;

   localparam logic [2:0] CSR_VERTEX_COUNT = 3'd0;

   typedef struct packed {
      logic                   action;
      logic [VID_BITS-1:0]    row_vertex;
      logic [VID_BITS-1:0]    col_vertex;
      logic [WEIGHT_BITS-1:0] edge_weight_in;
      logic [VID_BITS-1:0]    start_vertex;
   } req_type;

   typedef struct packed {
      logic [VID_BITS-1:0]    tree_source;
      logic [VID_BITS-1:0]    tree_target;
      logic [WEIGHT_BITS-1:0] tree_weight;
      logic [1:0]             status;
      logic                   last;
   } rsp_type;

   // one vertex as it travels around the ring
   typedef struct packed {
      logic [VID_BITS-1:0]    vid;
      logic                   active;
      logic                   in_tree;
      logic [WEIGHT_BITS-1:0] best_weight;
      logic [VID_BITS-1:0]    best_source;
      logic [VID_BITS-1:0]    best_rank;
   } cell_type;

   // broadcast to the head cell: vertex being joined and its matrix row entry
   typedef struct packed {
      logic [VID_BITS-1:0]    join_vid;
      logic [VID_BITS-1:0]    join_rank;
      logic [WEIGHT_BITS-1:0] row_weight;
   } relax_bus_type;

endpackage

>>> rtl/pmst_matrix.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmst_matrix: adjacency weight memory
// One write port and one registered read port.
// ---------------------------------------------------------------------------
module pmst_matrix
   import pmst_pkg::*;
(
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_BITS-1:0]   wr_addr,
   input  logic [WEIGHT_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0]   rd_addr,
   output logic [WEIGHT_BITS-1:0] rd_data
);

   logic [WEIGHT_BITS-1:0] mem [MAX_VERTICES*MAX_VERTICES];
   logic [WEIGHT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pmst_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmst_cell: one vertex slot of the ring
// Holds a vertex record; at the head it marks and relaxes the record.
// ---------------------------------------------------------------------------
module pmst_cell
   import pmst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  shift,
   input  logic                  is_head,
   input  logic [VID_BITS-1:0]   init_vid,
   input  logic [COUNT_BITS-1:0] vertex_limit,
   input  relax_bus_type         bus,
   input  cell_type              nbr_in,
   output cell_type              cell_out
);

   cell_type state_ff, state_in, proc;

   always_comb begin
      proc = state_ff;
      if (state_ff.vid == bus.join_vid) begin
         proc.in_tree = 1'b1;
      end else if (state_ff.active && !state_ff.in_tree && bus.row_weight != '0 &&
                   (state_ff.best_weight == '0 || bus.row_weight < state_ff.best_weight)) begin
         proc.best_weight = bus.row_weight;
         proc.best_source = bus.join_vid;
         proc.best_rank   = bus.join_rank;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (reset || clear) begin
         state_in             = '0;
         state_in.vid         = init_vid;
         state_in.active      = ({1'b0, init_vid} < vertex_limit);
      end else if (shift) begin
         state_in = nbr_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign cell_out = is_head ? proc : state_ff;

endmodule

>>> rtl/prim_minimum_spanning_tree_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prim_minimum_spanning_tree_core: Prim spanning tree over a weight matrix
//
// req channel (valid/stall): a load word writes one matrix weight. A run
// word grows a tree from start_vertex over the first vertex_count vertices
// and returns its edges on the rsp channel in order of addition, the last
// marked by last, or one status word.
// Vertex records circulate in a ring of 32 cells; each edge costs one full
// turn of the ring, with one read per cycle from the weight memory, plus a
// move of the word into the output register. req_stall is high for the
// whole run.
// rsp has one output register: while rsp_stall is high the word holds and
// the ring waits before emitting the next edge.
// Reset clears control state and vertex_count; the matrix is undefined
// until written. csr: vertex_count at byte address 0.
// ---------------------------------------------------------------------------
module prim_minimum_spanning_tree_core
   import pmst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SWEEP = 2'd1;
   localparam logic [1:0] S_EMIT  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] vcount_ff, vcount_in;
   logic [COUNT_BITS-1:0] n_ff, n_in, n_run;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [VID_BITS-1:0]   join_ff, join_in;
   logic [VID_BITS-1:0]   edges_ff, edges_in;
   logic                  fin_ff, fin_in;
   rsp_type               pend_ff, pend_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                   found_ff, found_in;
   logic [WEIGHT_BITS-1:0] pw_ff, pw_in;
   logic [VID_BITS-1:0]    prank_ff, prank_in;
   logic [VID_BITS-1:0]    pick_ff, pick_in;
   logic [VID_BITS-1:0]    psrc_ff, psrc_in;

   logic                   req_acc, clear, shift, rsp_free;
   logic [WEIGHT_BITS-1:0] rd_data;
   relax_bus_type          bus;
   cell_type               ring [MAX_VERTICES];
   cell_type               head;

   assign req_acc  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign shift    = (state_ff == S_SWEEP) && (cnt_ff != '0);
   assign clear    = req_acc && (req_data.action == ACT_RUN);
   assign n_run    = (vcount_ff > COUNT_BITS'(MAX_VERTICES)) ?
                     COUNT_BITS'(MAX_VERTICES) : vcount_ff;

   pmst_matrix u_matrix (
      .clock   (clock),
      .wr_en   (req_acc && req_data.action == ACT_LOAD),
      .wr_addr ({req_data.row_vertex, req_data.col_vertex}),
      .wr_data (req_data.edge_weight_in),
      .rd_addr ({join_ff, cnt_ff[VID_BITS-1:0]}),
      .rd_data (rd_data)
   );

   assign bus.join_vid   = join_ff;
   assign bus.join_rank  = edges_ff;
   assign bus.row_weight = rd_data;

   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      pmst_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .clear        (clear),
         .shift        (shift),
         .is_head      (i == 0),
         .init_vid     (VID_BITS'(i)),
         .vertex_limit (n_run),
         .bus          (bus),
         .nbr_in       (ring[(i + 1) % MAX_VERTICES]),
         .cell_out     (ring[i])
      );
   end

   assign head = ring[0];

   // running minimum over the head records, in vertex order
   always_comb begin
      found_in = found_ff;
      pw_in    = pw_ff;
      prank_in = prank_ff;
      pick_in  = pick_ff;
      psrc_in  = psrc_ff;
      if (state_ff != S_SWEEP) begin
         found_in = 1'b0;
      end else if (shift && head.active && !head.in_tree && head.best_weight != '0 &&
                   (!found_ff || head.best_weight < pw_ff ||
                    (head.best_weight == pw_ff && head.best_rank < prank_ff))) begin
         found_in = 1'b1;
         pw_in    = head.best_weight;
         prank_in = head.best_rank;
         pick_in  = head.vid;
         psrc_in  = head.best_source;
      end
   end

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      join_in      = join_ff;
      edges_in     = edges_ff;
      fin_in       = fin_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_VERTEX_COUNT) begin
         vcount_in = csr_pwdata[COUNT_BITS-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (clear) begin
               n_in     = n_run;
               join_in  = req_data.start_vertex;
               edges_in = '0;
               cnt_in   = '0;
               pend_in  = '0;
               fin_in   = 1'b1;
               if (n_run <= COUNT_BITS'(1)) begin
                  pend_in.status = ST_EMPTY;
                  pend_in.last   = 1'b1;
                  state_in       = S_EMIT;
               end else if ({1'b0, req_data.start_vertex} >= n_run) begin
                  pend_in.status = ST_DISCONN;
                  pend_in.last   = 1'b1;
                  state_in       = S_EMIT;
               end else begin
                  state_in = S_SWEEP;
               end
            end
         end
         S_SWEEP: begin
            cnt_in = cnt_ff + COUNT_BITS'(1);
            if (cnt_ff == COUNT_BITS'(MAX_VERTICES)) begin
               pend_in = '0;
               state_in = S_EMIT;
               if (!found_in) begin
                  pend_in.status = ST_DISCONN;
                  pend_in.last   = 1'b1;
                  fin_in         = 1'b1;
               end else begin
                  pend_in.tree_source = psrc_in;
                  pend_in.tree_target = pick_in;
                  pend_in.tree_weight = pw_in;
                  pend_in.status      = ST_EDGE;
                  pend_in.last        = ({1'b0, edges_ff} + COUNT_BITS'(2) == n_ff);
                  fin_in              = pend_in.last;
                  join_in             = pick_in;
                  edges_in            = edges_ff + VID_BITS'(1);
               end
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               cnt_in       = '0;
               state_in     = fin_ff ? S_IDLE : S_SWEEP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
      n_ff     <= n_in;
      cnt_ff   <= cnt_in;
      join_ff  <= join_in;
      edges_ff <= edges_in;
      fin_ff   <= fin_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
      pw_ff    <= pw_in;
      prank_ff <= prank_in;
      pick_ff  <= pick_in;
      psrc_ff  <= psrc_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_VERTEX_COUNT) ? {26'd0, vcount_ff} : 32'd0;

endmodule

>>> rtl/pmst_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmst_checker: port-level checks of the spanning tree core
// Watches the result channel and reset behavior.
// ---------------------------------------------------------------------------
module pmst_checker
   import pmst_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_EDGE |-> rsp_data.last)
      else $error("status word not marked last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_EDGE |->
         rsp_data.tree_weight == '0 && rsp_data.tree_source == '0)
      else $error("status word carries edge data");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind prim_minimum_spanning_tree_core pmst_checker u_pmst_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
